@@ hw/rtl/tqu_pkg.sv @@
`default_nettype none
package tqu_pkg;

   // default sizes
   localparam int VALUE_WIDTH_DEF    = 32;
   localparam int PROB_FRAC_BITS_DEF = 16;

   // register indexes on the csr port
   localparam logic [1:0] REG_LOWER = 2'd0;
   localparam logic [1:0] REG_UPPER = 2'd1;
   localparam logic [1:0] REG_PEAK  = 2'd2;

   // reset values, Q16.16
   localparam longint LOWER_RESET = 0;
   localparam longint UPPER_RESET = 65536;
   localparam longint PEAK_RESET  = 32768;

   // flags that travel beside each item
   typedef struct packed {
      logic sub;       // result is base minus root
      logic invalid;   // limits out of order or probability above one
   } flags_type;

endpackage
`default_nettype wire

@@ hw/rtl/tqu_req_if.sv @@
`default_nettype none
interface tqu_req_if #(
   parameter int PROB_WIDTH = tqu_pkg::PROB_FRAC_BITS_DEF + 1
);
   logic                  valid;
   logic                  ready;
   logic [PROB_WIDTH-1:0] prob;

   modport source (output valid, output prob, input ready);
   modport sink   (input valid, input prob, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tqu_rsp_if.sv @@
`default_nettype none
interface tqu_rsp_if #(
   parameter int VALUE_WIDTH = tqu_pkg::VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] quantile;
   logic                   invalid;

   modport source (output valid, output quantile, output invalid, input ready);
   modport sink   (input valid, input quantile, input invalid, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tqu_csr.sv @@
`default_nettype none
module tqu_csr #(
   parameter int VALUE_WIDTH = tqu_pkg::VALUE_WIDTH_DEF,
   parameter int DATA_WIDTH  = 32,
   parameter int ADDR_WIDTH  = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ADDR_WIDTH-1:0]         paddr,
   input  wire logic [DATA_WIDTH-1:0]         pwdata,
   output      logic [DATA_WIDTH-1:0]         prdata,
   output      logic                          pready,
   output      logic signed [VALUE_WIDTH-1:0] lower,
   output      logic signed [VALUE_WIDTH-1:0] upper,
   output      logic signed [VALUE_WIDTH-1:0] peak
);

   logic [VALUE_WIDTH-1:0] lower_ff, upper_ff, peak_ff;
   logic [1:0]             index;
   logic                   wr_en;

   assign index  = paddr[ADDR_WIDTH-1:ADDR_WIDTH-2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= VALUE_WIDTH'(tqu_pkg::LOWER_RESET);
         upper_ff <= VALUE_WIDTH'(tqu_pkg::UPPER_RESET);
         peak_ff  <= VALUE_WIDTH'(tqu_pkg::PEAK_RESET);
      end else if (wr_en) begin
         case (index)
            tqu_pkg::REG_LOWER: lower_ff <= pwdata[VALUE_WIDTH-1:0];
            tqu_pkg::REG_UPPER: upper_ff <= pwdata[VALUE_WIDTH-1:0];
            tqu_pkg::REG_PEAK:  peak_ff  <= pwdata[VALUE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // read back, sign extended
   always_comb begin
      case (index)
         tqu_pkg::REG_LOWER: prdata = DATA_WIDTH'($signed(lower_ff));
         tqu_pkg::REG_UPPER: prdata = DATA_WIDTH'($signed(upper_ff));
         tqu_pkg::REG_PEAK:  prdata = DATA_WIDTH'($signed(peak_ff));
         default:            prdata = '0;
      endcase
   end

   assign lower = lower_ff;
   assign upper = upper_ff;
   assign peak  = peak_ff;

   // a write to the mode register lands on the next edge
   assert property (@(posedge clock) disable iff (reset)
      wr_en && index == tqu_pkg::REG_PEAK |=> peak_ff == $past(pwdata[VALUE_WIDTH-1:0]))
      else $error("peak register write lost");

endmodule
`default_nettype wire

@@ hw/rtl/tqu_front.sv @@
`default_nettype none
module tqu_front #(
   parameter int VALUE_WIDTH    = tqu_pkg::VALUE_WIDTH_DEF,
   parameter int PROB_FRAC_BITS = tqu_pkg::PROB_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [PROB_FRAC_BITS:0]       prob,
   input  wire logic signed [VALUE_WIDTH-1:0] lower,
   input  wire logic signed [VALUE_WIDTH-1:0] upper,
   input  wire logic signed [VALUE_WIDTH-1:0] peak,
   output      logic                          out_valid,
   output      logic [2*VALUE_WIDTH-1:0]      radicand,
   output      logic [VALUE_WIDTH-1:0]        base,
   output      tqu_pkg::flags_type            flags
);

   localparam int VW = VALUE_WIDTH;
   localparam int PW = PROB_FRAC_BITS + 1;
   localparam int LW = VW + PW;               // p * span
   localparam int RW = 2 * VW;                // radicand
   localparam int SW = RW + PW;               // partial product sum
   localparam logic [PW-1:0] ONE = PW'(1) << PROB_FRAC_BITS;

   // stage 1: differences, range checks, inflection product
   logic          v1_ff, bad1_ff;
   logic [PW-1:0] p1_ff;
   logic [VW-1:0] a1_ff, b1_ff, c1_ff, span1_ff, dl1_ff, dh1_ff;
   logic [LW-1:0] lhs1_ff;
   logic          bad1_in;
   logic [VW-1:0] span_in;

   assign bad1_in = (prob > ONE) || (peak < lower) || (upper < peak);

   // span is unsigned once the limits are in order
   assign span_in = upper - lower;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bad1_ff  <= bad1_in;
         p1_ff    <= prob;
         a1_ff    <= lower;
         b1_ff    <= upper;
         c1_ff    <= peak;
         span1_ff <= span_in;
         dl1_ff   <= peak - lower;
         dh1_ff   <= upper - peak;
         lhs1_ff  <= LW'(prob) * LW'(span_in);
      end
   end

   // stage 2: pick the side of the mode
   logic              v2_ff;
   logic [PW-1:0]     pm2_ff;
   logic [VW-1:0]     span2_ff, d2_ff, base2_ff;
   tqu_pkg::flags_type fl2_ff;
   logic [LW-1:0]     rhs;
   logic              lt, gt;

   assign rhs = LW'(dl1_ff) << PROB_FRAC_BITS;
   assign lt  = lhs1_ff < rhs;
   assign gt  = rhs < lhs1_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         span2_ff       <= span1_ff;
         pm2_ff         <= lt ? p1_ff : ONE - p1_ff;
         d2_ff          <= lt ? dl1_ff : (gt ? dh1_ff : '0);
         base2_ff       <= lt ? a1_ff : (gt ? b1_ff : c1_ff);
         fl2_ff.sub     <= !lt && gt;
         fl2_ff.invalid <= bad1_ff;
      end
   end

   // stage 3: span times distance
   logic              v3_ff;
   logic [RW-1:0]     m3_ff;
   logic [PW-1:0]     pm3_ff;
   logic [VW-1:0]     base3_ff;
   tqu_pkg::flags_type fl3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff    <= RW'(span2_ff) * RW'(d2_ff);
         pm3_ff   <= pm2_ff;
         base3_ff <= base2_ff;
         fl3_ff   <= fl2_ff;
      end
   end

   // stage 4: two partial products with the probability
   logic              v4_ff;
   logic [LW-1:0]     pl4_ff, ph4_ff;
   logic [VW-1:0]     base4_ff;
   tqu_pkg::flags_type fl4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl4_ff   <= LW'(m3_ff[VW-1:0]) * LW'(pm3_ff);
         ph4_ff   <= LW'(m3_ff[RW-1:VW]) * LW'(pm3_ff);
         base4_ff <= base3_ff;
         fl4_ff   <= fl3_ff;
      end
   end

   // stage 5: sum and drop the probability fraction
   logic              v5_ff;
   logic [RW-1:0]     rad5_ff;
   logic [VW-1:0]     base5_ff;
   tqu_pkg::flags_type fl5_ff;
   logic [SW-1:0]     sum5;

   assign sum5 = (SW'(ph4_ff) << VW) + SW'(pl4_ff);

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad5_ff  <= sum5[PROB_FRAC_BITS +: RW];
         base5_ff <= base4_ff;
         fl5_ff   <= fl4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign radicand  = rad5_ff;
   assign base      = base5_ff;
   assign flags     = fl5_ff;

endmodule
`default_nettype wire

@@ hw/rtl/tqu_isqrt.sv @@
`default_nettype none
module tqu_isqrt #(
   parameter int VALUE_WIDTH = tqu_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic [2*VALUE_WIDTH-1:0] radicand,
   input  wire logic [VALUE_WIDTH-1:0]   in_base,
   input  wire tqu_pkg::flags_type       in_flags,
   output      logic                     out_valid,
   output      logic [VALUE_WIDTH-1:0]   root,
   output      logic [VALUE_WIDTH-1:0]   out_base,
   output      tqu_pkg::flags_type       out_flags
);

   localparam int VW = VALUE_WIDTH;
   localparam int RW = 2 * VW;

   // one root bit per stage, most significant first
   logic               vld_ff  [VW];
   logic [RW-1:0]      rem_ff  [VW];
   logic [VW-1:0]      root_ff [VW];
   logic [VW-1:0]      base_ff [VW];
   tqu_pkg::flags_type flag_ff [VW];

   logic               stg_vld  [VW];
   logic [RW-1:0]      stg_rem  [VW];
   logic [VW-1:0]      stg_root [VW];
   logic [VW-1:0]      stg_base [VW];
   tqu_pkg::flags_type stg_flag [VW];

   for (genvar s = 0; s < VW; s++) begin : g_stage
      localparam int B = VW - 1 - s;
      logic [RW:0] trial;
      logic        take;

      // stage input from the port or the previous stage
      if (s == 0) begin : g_first
         assign stg_vld[s]  = in_valid;
         assign stg_rem[s]  = radicand;
         assign stg_root[s] = '0;
         assign stg_base[s] = in_base;
         assign stg_flag[s] = in_flags;
      end else begin : g_next
         assign stg_vld[s]  = vld_ff[s-1];
         assign stg_rem[s]  = rem_ff[s-1];
         assign stg_root[s] = root_ff[s-1];
         assign stg_base[s] = base_ff[s-1];
         assign stg_flag[s] = flag_ff[s-1];
      end

      // trial subtrahend (2r + 2^b) * 2^b
      assign trial = ((RW+1)'(stg_root[s]) << (B + 1)) + ((RW+1)'(1) << (2 * B));
      assign take  = {1'b0, stg_rem[s]} >= trial;

      always_ff @(posedge clock) begin
         if (reset) vld_ff[s] <= 1'b0;
         else if (en) vld_ff[s] <= stg_vld[s];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? stg_rem[s] - trial[RW-1:0] : stg_rem[s];
            root_ff[s] <= take ? stg_root[s] | (VW'(1) << B) : stg_root[s];
            base_ff[s] <= stg_base[s];
            flag_ff[s] <= stg_flag[s];
         end
      end
   end

   assign out_valid = vld_ff[VW-1];
   assign root      = root_ff[VW-1];
   assign out_base  = base_ff[VW-1];
   assign out_flags = flag_ff[VW-1];

   // finished root is the floor: remainder no more than twice the root
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[VW-1] |-> rem_ff[VW-1] <= (RW'(root_ff[VW-1]) << 1))
      else $error("square root remainder too large");

   // a held stage keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      !en && vld_ff[VW-1] |=> $stable(root_ff[VW-1]) && vld_ff[VW-1])
      else $error("square root stage changed while stalled");

endmodule
`default_nettype wire

@@ hw/rtl/triangular_quantile_unit.sv @@
`default_nettype none
// triangular distribution quantile (inverse cdf), fixed point
// req_ch carries a probability prob, unsigned with PROB_FRAC_BITS fraction bits
// (one = 2^PROB_FRAC_BITS); rsp_ch returns one item per request: quantile, signed
// Q16.16, and invalid, set with a zero quantile when the limits are out of order
// or prob exceeds one.
// lower limit, upper limit and mode sit behind the apb-style port at 4*i
// (8*i when VALUE_WIDTH exceeds 32); write them only while no item is in flight.
// range checks and multiplication come first, then one square root bit per stage,
// then one output register. a new item is taken every cycle while no result waits
// at the output; the square root pipeline has one stage per result bit.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// req_ch.ready drops; nothing is lost or repeated. items already in flight stay
// put until the result is taken.
// reset empties the pipeline and loads lower 0, upper 1.0 and mode 0.5.
module triangular_quantile_unit #(
   parameter int VALUE_WIDTH    = tqu_pkg::VALUE_WIDTH_DEF,
   parameter int PROB_FRAC_BITS = tqu_pkg::PROB_FRAC_BITS_DEF,
   localparam int CSR_DW = (VALUE_WIDTH > 32) ? 64 : 32,
   localparam int CSR_AW = (VALUE_WIDTH > 32) ? 5 : 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tqu_req_if.sink                req_ch,
   tqu_rsp_if.source              rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output      logic [CSR_DW-1:0] prdata,
   output      logic              pready
);

   localparam int VW = VALUE_WIDTH;

   logic signed [VW-1:0] lower, upper, peak;
   logic                 en;
   logic                 fr_valid, sq_valid;
   logic [2*VW-1:0]      fr_rad;
   logic [VW-1:0]        fr_base, sq_root, sq_base;
   tqu_pkg::flags_type   fr_flags, sq_flags;

   logic                 rsp_valid_ff, rsp_invalid_ff;
   logic [VW-1:0]        rsp_quant_ff, rsp_quant_in;

   // pipeline moves whenever the output register is free or being taken
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   tqu_csr #(
      .VALUE_WIDTH (VW),
      .DATA_WIDTH  (CSR_DW),
      .ADDR_WIDTH  (CSR_AW)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .lower   (lower),
      .upper   (upper),
      .peak    (peak)
   );

   tqu_front #(
      .VALUE_WIDTH    (VW),
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .prob      (req_ch.prob),
      .lower     (lower),
      .upper     (upper),
      .peak      (peak),
      .out_valid (fr_valid),
      .radicand  (fr_rad),
      .base      (fr_base),
      .flags     (fr_flags)
   );

   tqu_isqrt #(
      .VALUE_WIDTH (VW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .radicand  (fr_rad),
      .in_base   (fr_base),
      .in_flags  (fr_flags),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_base  (sq_base),
      .out_flags (sq_flags)
   );

   // final offset from the chosen limit
   always_comb begin
      if (sq_flags.invalid) rsp_quant_in = '0;
      else if (sq_flags.sub) rsp_quant_in = sq_base - sq_root;
      else rsp_quant_in = sq_base + sq_root;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= sq_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_quant_ff   <= rsp_quant_in;
         rsp_invalid_ff <= sq_flags.invalid;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.quantile = rsp_quant_ff;
   assign rsp_ch.invalid  = rsp_invalid_ff;

   // an invalid item always carries a zero quantile
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_invalid_ff |-> rsp_quant_ff == '0)
      else $error("invalid item with non-zero quantile");

   // a waiting result blocks new items
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready && !u_isqrt.en)
      else $error("pipeline advanced past a waiting result");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QW = tqu_pkg::VALUE_WIDTH_DEF;
   localparam int FB = tqu_pkg::PROB_FRAC_BITS_DEF;
   localparam int PW = FB + 1;
   localparam logic [PW-1:0] PROB_ONE = PW'(1) << FB;
   localparam int DRAIN_CYCLES = QW + 6 + 10;

   typedef struct {
      logic [QW-1:0] quantile;
      logic          invalid;
   } quantile_result_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;

   tqu_req_if #(.PROB_WIDTH(PW)) req_ch ();
   tqu_rsp_if #(.VALUE_WIDTH(QW)) rsp_ch ();

   triangular_quantile_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch.sink),
      .rsp_ch  (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // shadow copy of the distribution limits
   logic signed [QW-1:0] lower_lim, upper_lim, mode_pt;

   quantile_result_type expected_quantiles[$];
   int mismatches;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_cycles;

   // square root, rounding down
   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0]  r;
      logic [127:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = {64'd0, r | (64'd1 << b)};
         if (t * t <= x) r = t[63:0];
      end
      return r;
   endfunction

   // quantile of the configured triangle at probability p
   function automatic quantile_result_type triangle_quantile(input logic [PW-1:0] p);
      quantile_result_type res;
      longint a, b, c, span, dl, dh, q;
      logic [127:0] span_w, dl_w, dh_w, p_w, lhs, rhs;
      a = longint'(lower_lim);
      b = longint'(upper_lim);
      c = longint'(mode_pt);
      res.invalid  = 1'b0;
      res.quantile = '0;
      if (p > PROB_ONE || c < a || b < c) begin
         res.invalid = 1'b1;
         return res;
      end
      span   = b - a;
      dl     = c - a;
      dh     = b - c;
      span_w = span;
      dl_w   = dl;
      dh_w   = dh;
      p_w    = p;
      lhs    = p_w * span_w;
      rhs    = dl_w << FB;
      if (lhs < rhs)
         q = a + longint'(floor_sqrt((span_w * dl_w * p_w) >> FB));
      else if (rhs < lhs)
         q = b - longint'(floor_sqrt((span_w * dh_w * (PROB_ONE - p_w)) >> FB));
      else
         q = c;
      res.quantile = q[QW-1:0];
      return res;
   endfunction

   // apb write, setup then access
   task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tqu_pkg::REG_LOWER: lower_lim = value;
         tqu_pkg::REG_UPPER: upper_lim = value;
         tqu_pkg::REG_PEAK:  mode_pt   = value;
         default: ;
      endcase
   endtask

   task automatic set_triangle(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] pk);
      write_limit(tqu_pkg::REG_LOWER, lo);
      write_limit(tqu_pkg::REG_UPPER, hi);
      write_limit(tqu_pkg::REG_PEAK, pk);
   endtask

   // send one item, valid stays high when the next follows at once
   task automatic send_prob(input logic [PW-1:0] p);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.prob  <= p;
      do @(posedge clock); while (!req_ch.ready);
      expected_quantiles.push_back(triangle_quantile(p));
   endtask

   // wait for every result, then for the pipeline to settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      wait (expected_quantiles.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PW-1:0] random_prob();
      int sel;
      sel = $urandom_range(99);
      if (sel < 6) return PW'($urandom_range(2 ** PW - 1, PROB_ONE + 1));
      if (sel < 10) return (sel < 8) ? '0 : PROB_ONE;
      return PW'($urandom_range(PROB_ONE));
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 ** 20)) - (2 ** 19));
         2: return 32'($signed($urandom_range(8)) - 4) <<< 16;
         default: return $urandom_range(1 << 17);
      endcase
   endfunction

   // receiver: random stalls plus a counted hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ch.ready    <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      quantile_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_quantiles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: quantile %h invalid %b",
                        rsp_ch.quantile, rsp_ch.invalid);
         end else begin
            exp_res = expected_quantiles.pop_front();
            if (rsp_ch.quantile !== exp_res.quantile || rsp_ch.invalid !== exp_res.invalid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected quantile %h invalid %b, got %h %b",
                           exp_res.quantile, exp_res.invalid,
                           rsp_ch.quantile, rsp_ch.invalid);
            end
         end
      end
   end

   // reset values, endpoints and probabilities above one
   task automatic test_reset_limits();
      logic [PW-1:0] probes[9] = '{0, 1, 16384, 32767, 32768, 32769, 65535,
                                   PROB_ONE, PROB_ONE + 1};
      foreach (probes[i]) send_prob(probes[i]);
      send_prob('1);
      drain();
   endtask

   // extremes, degenerate support, mode at either end, limits out of order
   task automatic test_corner_triangles();
      set_triangle(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      send_prob('0); send_prob(PROB_ONE); send_prob(32768); send_prob(1); send_prob(65535);
      drain();
      set_triangle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_prob('0); send_prob(PROB_ONE); send_prob(12345);
      drain();
      set_triangle(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_prob('0); send_prob(PROB_ONE); send_prob(54321);
      drain();
      set_triangle(32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
      send_prob('0); send_prob(PROB_ONE); send_prob(777);
      drain();
      set_triangle(32'h0001_0000, 32'h0002_0000, 32'h0000_0000);
      send_prob(100); send_prob(PROB_ONE);
      drain();
      set_triangle(32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
      send_prob(100);
      drain();
   endtask

   // random triangles under each idling pattern
   task automatic test_random_stream();
      int idle_pct[4] = '{0, 65, 0, 29};
      int stall_pct[4] = '{0, 0, 65, 29};
      logic signed [31:0] v0, v1, v2, t;
      for (int ph = 0; ph < 16; ph++) begin
         send_idle_pct  = idle_pct[ph % 4];
         recv_stall_pct = stall_pct[ph % 4];
         v0 = random_value();
         v1 = random_value();
         v2 = random_value();
         // mostly ordered limits, sometimes left as drawn
         if ($urandom_range(9) != 0) begin
            if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
            if (v1 > v2) begin t = v1; v1 = v2; v2 = t; end
            if (v0 > v1) begin t = v0; v0 = v1; v1 = t; end
            set_triangle(v0, v2, v1);
         end else begin
            set_triangle(v0, v1, v2);
         end
         repeat (80) send_prob(random_prob());
         drain();
      end
   endtask

   // long receiver hold-off, then a pause until everything is back
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 10;
      set_triangle(32'hfffe_0000, 32'h0005_0000, 32'h0001_8000);
      hold_off_cycles = 200;
      repeat (100) send_prob(random_prob());
      req_ch.valid <= 1'b0;
      wait (expected_quantiles.size() == 0);
      repeat (60) send_prob(random_prob());
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_ch.valid    = 1'b0;
      req_ch.prob     = '0;
      rsp_ch.ready    = 1'b0;
      mismatches      = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 0;
      lower_lim       = QW'(tqu_pkg::LOWER_RESET);
      upper_lim       = QW'(tqu_pkg::UPPER_RESET);
      mode_pt         = QW'(tqu_pkg::PEAK_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_limits();
      test_corner_triangles();
      test_random_stream();
      test_backpressure();
      if (mismatches == 0 && expected_quantiles.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

@@ triangular_quantile_unit.f @@
hw/rtl/tqu_pkg.sv
hw/rtl/tqu_req_if.sv
hw/rtl/tqu_rsp_if.sv
hw/rtl/tqu_csr.sv
hw/rtl/tqu_front.sv
hw/rtl/tqu_isqrt.sv
hw/rtl/triangular_quantile_unit.sv
sim/tb_top.sv
